[rtl/cblfc_pkg.sv]
// cblfc_pkg: shared constants for the bank latch and flash command block
package cblfc_pkg;

    localparam int unsigned ADDR_W       = 15;
    localparam int unsigned DATA_W       = 8;
    localparam int unsigned FLASH_ADDR_W = 19;
    localparam int unsigned BANK_W       = 5;
    localparam int unsigned WINDOW_BITS  = 14;
    localparam int unsigned SECTOR_BYTES = 4096;
    localparam int unsigned SECTOR_BITS  = $clog2(SECTOR_BYTES);

    localparam int unsigned CMD_DEPTH = 6;
    localparam int unsigned CNT_W     = $clog2(CMD_DEPTH + 1);

    // command address / data pairs of the flash unlock and command sequences
    localparam logic [ADDR_W-1:0] CMD_ADDR_HI = 15'h5555;
    localparam logic [ADDR_W-1:0] CMD_ADDR_LO = 15'h2AAA;
    localparam logic [11:0]       CMD_LOW_HI  = 12'h555;
    localparam logic [11:0]       CMD_LOW_LO  = 12'hAAA;

    localparam logic [DATA_W-1:0] CMD_UNLOCK1  = 8'hAA;
    localparam logic [DATA_W-1:0] CMD_UNLOCK2  = 8'h55;
    localparam logic [DATA_W-1:0] CMD_ERASE    = 8'h80;
    localparam logic [DATA_W-1:0] CMD_SECTOR   = 8'h30;
    localparam logic [DATA_W-1:0] CMD_CHIP     = 8'h10;
    localparam logic [DATA_W-1:0] CMD_PROGRAM  = 8'hA0;
    localparam logic [DATA_W-1:0] CMD_ID_ENTRY = 8'h90;
    localparam logic [DATA_W-1:0] CMD_RESET    = 8'hF0;
    localparam logic [DATA_W-1:0] ERASED_BYTE  = 8'hFF;

    // flash action codes
    localparam logic [2:0] FA_NONE    = 3'd0;
    localparam logic [2:0] FA_PROGRAM = 3'd1;
    localparam logic [2:0] FA_SECTOR  = 3'd2;
    localparam logic [2:0] FA_CHIP    = 3'd3;
    localparam logic [2:0] FA_REFUSED = 3'd4;

    // prg source codes
    localparam logic [1:0] SRC_ROM   = 2'd0;
    localparam logic [1:0] SRC_FLASH = 2'd1;
    localparam logic [1:0] SRC_ID    = 2'd2;

    // configuration register indexes
    localparam logic CFG_FLASH_EN     = 1'b0;
    localparam logic CFG_BUS_CONFLICT = 1'b1;

endpackage

[rtl/cartridge_bank_latch_flash_commands.sv]
// cartridge_bank_latch_flash_commands: bank latch with flash command recogniser
//
// One request on the s_ channel is one cpu write in the $8000-$ffff window:
// offset, data byte and the byte currently readable there. Every request
// gives exactly one result on the m_ channel: bank fields after the write,
// prg source and the flash action (program, sector/chip erase, refused).
// m_valid rises in the cycle after acceptance; the decode and the state
// update are done in the accept cycle and the result sits in the output
// register. Throughput is one request per cycle: s_ready is high whenever
// the output register is empty or is being emptied in the same cycle.
// When the receiver stalls, the result holds and s_ready drops until taken.
// Synchronous active-low reset clears the latch, command count, id mode,
// flash enable and output valid, and sets bus conflict emulation on.
// Configuration writes land at once through cfg_we / cfg_index / cfg_data
// and are expected only while no request is in flight.
module cartridge_bank_latch_flash_commands
    import cblfc_pkg::*;
#(
    parameter int unsigned PRG_BANK_BITS = 5
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic                    cfg_data,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [ADDR_W-1:0]       s_write_address,
    input  logic [DATA_W-1:0]       s_write_data,
    input  logic [DATA_W-1:0]       s_current_byte,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [BANK_W-1:0]       m_prg_bank,
    output logic [1:0]              m_chr_bank,
    output logic                    m_screen_select,
    output logic [1:0]              m_prg_source,
    output logic [2:0]              m_flash_action,
    output logic [FLASH_ADDR_W-1:0] m_flash_address,
    output logic [DATA_W-1:0]       m_program_data
);

    localparam logic [BANK_W-1:0] PRG_MASK = BANK_W'((1 << PRG_BANK_BITS) - 1);

    logic              flash_en_reg;
    logic              bus_conflict_reg;
    logic [7:0]        latch_reg, latch_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, cnt_inc;
    logic              id_reg, id_next;
    logic [ADDR_W-1:0] cmd_addr_reg [CMD_DEPTH];
    logic [DATA_W-1:0] cmd_val_reg  [CMD_DEPTH];
    logic [ADDR_W-1:0] ent_addr [CMD_DEPTH];
    logic [DATA_W-1:0] ent_val  [CMD_DEPTH];
    logic              m_valid_reg;

    logic                    accept;
    logic                    is_cmd;
    logic                    ent_we;
    logic                    pre;
    logic [ADDR_W-1:0]       new_entry;
    logic [FLASH_ADDR_W-1:0] offset;
    logic [2:0]              action;
    logic [FLASH_ADDR_W-1:0] faddr;
    logic [DATA_W-1:0]       pdata;

    function automatic logic ent_is(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] v,
                                    input logic [ADDR_W-1:0] ea, input logic [DATA_W-1:0] ev);
        return (a == ea) && (v == ev);
    endfunction

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    assign new_entry = {latch_reg[0], s_write_address[WINDOW_BITS-1:0]};
    assign offset    = {latch_reg[BANK_W-1:0] & PRG_MASK, s_write_address[WINDOW_BITS-1:0]};
    assign is_cmd    = flash_en_reg && !s_write_address[WINDOW_BITS];

    // the entry being written this cycle takes part in the match
    always_comb begin
        for (int i = 0; i < CMD_DEPTH; i++) begin
            ent_addr[i] = (cnt_reg == CNT_W'(i)) ? new_entry    : cmd_addr_reg[i];
            ent_val[i]  = (cnt_reg == CNT_W'(i)) ? s_write_data : cmd_val_reg[i];
        end
    end

    assign pre = ent_is(ent_addr[0], ent_val[0], CMD_ADDR_HI, CMD_UNLOCK1)
              && ent_is(ent_addr[1], ent_val[1], CMD_ADDR_LO, CMD_UNLOCK2);
    assign cnt_inc = cnt_reg + CNT_W'(1);

    always_comb begin
        latch_next = latch_reg;
        cnt_next   = cnt_reg;
        id_next    = id_reg;
        action     = FA_NONE;
        faddr      = '0;
        pdata      = '0;
        ent_we     = 1'b0;
        if (is_cmd) begin
            if (cnt_reg < CNT_W'(CMD_DEPTH)) begin
                ent_we   = 1'b1;
                cnt_next = cnt_inc;
                if (cnt_inc == CNT_W'(3) && pre
                        && ent_is(ent_addr[2], ent_val[2], CMD_ADDR_HI, CMD_ID_ENTRY)) begin
                    id_next  = 1'b1;
                    cnt_next = '0;
                end else if (cnt_inc == CNT_W'(4) && pre
                        && ent_is(ent_addr[2], ent_val[2], CMD_ADDR_HI, CMD_PROGRAM)) begin
                    faddr    = offset;
                    cnt_next = '0;
                    if (s_current_byte != ERASED_BYTE) begin
                        action = FA_REFUSED;
                    end else begin
                        action = FA_PROGRAM;
                        pdata  = s_write_data;
                    end
                end else if (cnt_inc == CNT_W'(CMD_DEPTH) && pre
                        && ent_is(ent_addr[2], ent_val[2], CMD_ADDR_HI, CMD_ERASE)
                        && ent_is(ent_addr[3], ent_val[3], CMD_ADDR_HI, CMD_UNLOCK1)
                        && ent_is(ent_addr[4], ent_val[4], CMD_ADDR_LO, CMD_UNLOCK2)) begin
                    if (ent_val[5] == CMD_SECTOR) begin
                        action   = FA_SECTOR;
                        faddr    = {offset[FLASH_ADDR_W-1:SECTOR_BITS], SECTOR_BITS'(0)};
                        cnt_next = '0;
                    end else if (ent_is(ent_addr[5], ent_val[5], CMD_ADDR_HI, CMD_CHIP)) begin
                        action   = FA_CHIP;
                        cnt_next = '0;
                    end
                end
            end
            // writes off the command addresses abort the sequence
            if (s_write_address[11:0] != CMD_LOW_LO && s_write_address[11:0] != CMD_LOW_HI) begin
                cnt_next = '0;
            end
            if (s_write_data == CMD_RESET) begin
                cnt_next = '0;
                id_next  = 1'b0;
            end
        end else begin
            latch_next = bus_conflict_reg ? (s_write_data & s_current_byte) : s_write_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flash_en_reg     <= 1'b0;
            bus_conflict_reg <= 1'b1;
            latch_reg        <= '0;
            cnt_reg          <= '0;
            id_reg           <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_FLASH_EN:     flash_en_reg     <= cfg_data;
                    CFG_BUS_CONFLICT: bus_conflict_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                latch_reg   <= latch_next;
                cnt_reg     <= cnt_next;
                id_reg      <= id_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // command buffer and result payload
    always_ff @(posedge aclk) begin
        if (accept && ent_we) begin
            cmd_addr_reg[cnt_reg[CNT_W-1:0]] <= new_entry;
            cmd_val_reg[cnt_reg[CNT_W-1:0]]  <= s_write_data;
        end
        if (accept) begin
            m_prg_bank      <= latch_next[BANK_W-1:0] & PRG_MASK;
            m_chr_bank      <= latch_next[6:5];
            m_screen_select <= latch_next[7];
            m_prg_source    <= flash_en_reg ? (id_next ? SRC_ID : SRC_FLASH) : SRC_ROM;
            m_flash_action  <= action;
            m_flash_address <= faddr;
            m_program_data  <= pdata;
        end
    end

endmodule

[rtl/cblfc_checker.sv]
// cblfc_checker: port-level assertions for the bank latch block, bound to the top level
module cblfc_checker
    import cblfc_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [BANK_W-1:0]       m_prg_bank,
    input logic [2:0]              m_flash_action,
    input logic [FLASH_ADDR_W-1:0] m_flash_address,
    input logic [DATA_W-1:0]       m_program_data
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_flash_action)
                                && $stable(m_flash_address) && $stable(m_prg_bank))
        else $error("result changed while stalled");

    // an empty output register never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // every accepted request shows a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted request gave no result");

    // program data only travels with a program action
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_flash_action != FA_PROGRAM |-> m_program_data == '0)
        else $error("program data without program action");

    // the low sector-offset address bits are zero for no action, chip erase and sector erase
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_flash_action == FA_NONE || m_flash_action == FA_CHIP
                    || m_flash_action == FA_SECTOR)
        |-> m_flash_address[SECTOR_BITS-1:0] == '0)
        else $error("flash address not aligned or not zero");

endmodule

bind cartridge_bank_latch_flash_commands cblfc_checker u_cblfc_checker (.*);

[tb/sv/tb_top.sv]
// tb_top: self-checking testbench for the bank latch and flash command recogniser
module tb_top;
    import cblfc_pkg::*;

    localparam int unsigned PRG_BANK_BITS = 5;
    localparam int unsigned ITEM_TARGET   = 1650;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned GAP_MAX       = 18;
    localparam int unsigned LATCH_LOW     = 1 << WINDOW_BITS;
    localparam logic [BANK_W-1:0] BANK_MASK = BANK_W'((1 << PRG_BANK_BITS) - 1);
    // command addresses as seen inside the $8000-$bfff window
    localparam logic [ADDR_W-1:0] HI_WIN = {1'b0, CMD_ADDR_HI[WINDOW_BITS-1:0]};
    localparam logic [ADDR_W-1:0] LO_WIN = {1'b0, CMD_ADDR_LO[WINDOW_BITS-1:0]};

    typedef struct packed {
        logic [BANK_W-1:0]       prg_bank;
        logic [1:0]              chr_bank;
        logic                    screen_select;
        logic [1:0]              prg_source;
        logic [2:0]              flash_action;
        logic [FLASH_ADDR_W-1:0] flash_address;
        logic [DATA_W-1:0]       program_data;
    } bank_result_t;

    typedef struct packed {
        logic              hi;
        logic [DATA_W-1:0] val;
    } cmd_step_t;

    typedef enum logic [1:0] {SEQ_ID, SEQ_PROGRAM, SEQ_SECTOR, SEQ_CHIP} flash_seq_t;
    typedef enum logic [1:0] {BREAK_DATA, BREAK_BANK, BREAK_NOISE, BREAK_RESET} seq_fault_t;

    logic                    aclk            = 1'b0;
    logic                    aresetn         = 1'b0;
    logic                    cfg_we          = 1'b0;
    logic                    cfg_index       = 1'b0;
    logic                    cfg_data        = 1'b0;
    logic                    s_valid         = 1'b0;
    logic                    s_ready;
    logic [ADDR_W-1:0]       s_write_address = '0;
    logic [DATA_W-1:0]       s_write_data    = '0;
    logic [DATA_W-1:0]       s_current_byte  = '0;
    logic                    m_valid;
    logic                    m_ready         = 1'b0;
    logic [BANK_W-1:0]       m_prg_bank;
    logic [1:0]              m_chr_bank;
    logic                    m_screen_select;
    logic [1:0]              m_prg_source;
    logic [2:0]              m_flash_action;
    logic [FLASH_ADDR_W-1:0] m_flash_address;
    logic [DATA_W-1:0]       m_program_data;

    // predictor state
    logic              flash_on;
    logic              conflict_on;
    logic              id_on;
    logic [7:0]        bank_latch_q;
    int unsigned       cmd_fill;
    logic [ADDR_W-1:0] cmd_addr_q [CMD_DEPTH];
    logic [DATA_W-1:0] cmd_data_q [CMD_DEPTH];

    bank_result_t pending_mappings [$];
    bank_result_t want_map;
    int unsigned  items_sent   = 0;
    int unsigned  results_seen = 0;
    int unsigned  mismatches   = 0;
    int unsigned  stall_left   = 0;
    bit           no_gaps      = 1'b0;

    cartridge_bank_latch_flash_commands #(
        .PRG_BANK_BITS(PRG_BANK_BITS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_write_address(s_write_address),
        .s_write_data   (s_write_data),
        .s_current_byte (s_current_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_prg_bank     (m_prg_bank),
        .m_chr_bank     (m_chr_bank),
        .m_screen_select(m_screen_select),
        .m_prg_source   (m_prg_source),
        .m_flash_action (m_flash_action),
        .m_flash_address(m_flash_address),
        .m_program_data (m_program_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("cartridge_bank_latch_flash_commands: mismatch");
        $finish;
    end

    function automatic logic cmd_entry_is(input int unsigned i, input logic [ADDR_W-1:0] a,
                                          input logic [DATA_W-1:0] v);
        return cmd_addr_q[i] == a && cmd_data_q[i] == v;
    endfunction

    function automatic bank_result_t decode_cpu_write(input logic [ADDR_W-1:0] addr,
                                                      input logic [DATA_W-1:0] data,
                                                      input logic [DATA_W-1:0] cur);
        bank_result_t            r;
        logic [FLASH_ADDR_W-1:0] offs;
        logic                    unlocked;
        r = '0;
        if (flash_on && !addr[WINDOW_BITS]) begin
            offs = {bank_latch_q[BANK_W-1:0] & BANK_MASK, addr[WINDOW_BITS-1:0]};
            if (cmd_fill < CMD_DEPTH) begin
                // stored address carries latch bit 0 as its top bit
                cmd_addr_q[cmd_fill] = {bank_latch_q[0], addr[WINDOW_BITS-1:0]};
                cmd_data_q[cmd_fill] = data;
                cmd_fill++;
                unlocked = cmd_entry_is(0, CMD_ADDR_HI, CMD_UNLOCK1) &&
                           cmd_entry_is(1, CMD_ADDR_LO, CMD_UNLOCK2);
                if (cmd_fill == 3 && unlocked && cmd_entry_is(2, CMD_ADDR_HI, CMD_ID_ENTRY)) begin
                    id_on    = 1'b1;
                    cmd_fill = 0;
                end else if (cmd_fill == 4 && unlocked &&
                             cmd_entry_is(2, CMD_ADDR_HI, CMD_PROGRAM)) begin
                    r.flash_address = offs;
                    if (cur != ERASED_BYTE) begin
                        r.flash_action = FA_REFUSED;
                    end else begin
                        r.flash_action = FA_PROGRAM;
                        r.program_data = data;
                    end
                    cmd_fill = 0;
                end else if (cmd_fill == CMD_DEPTH && unlocked &&
                             cmd_entry_is(2, CMD_ADDR_HI, CMD_ERASE) &&
                             cmd_entry_is(3, CMD_ADDR_HI, CMD_UNLOCK1) &&
                             cmd_entry_is(4, CMD_ADDR_LO, CMD_UNLOCK2)) begin
                    if (cmd_data_q[5] == CMD_SECTOR) begin
                        r.flash_action  = FA_SECTOR;
                        r.flash_address = (offs >> SECTOR_BITS) << SECTOR_BITS;
                        cmd_fill        = 0;
                    end else if (cmd_entry_is(5, CMD_ADDR_HI, CMD_CHIP)) begin
                        r.flash_action = FA_CHIP;
                        cmd_fill       = 0;
                    end
                end
            end
            if (addr[11:0] != CMD_LOW_HI && addr[11:0] != CMD_LOW_LO) begin
                cmd_fill = 0;
            end
            if (data == CMD_RESET) begin
                cmd_fill = 0;
                id_on    = 1'b0;
            end
        end else begin
            bank_latch_q = conflict_on ? (data & cur) : data;
        end
        r.prg_bank      = bank_latch_q[BANK_W-1:0] & BANK_MASK;
        r.chr_bank      = bank_latch_q[6:5];
        r.screen_select = bank_latch_q[7];
        r.prg_source    = !flash_on ? SRC_ROM : (id_on ? SRC_ID : SRC_FLASH);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] result %0d: %s", $time, results_seen, msg);
    endtask

    // result side: random back-pressure and comparison against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else if (m_valid && m_ready) begin
            results_seen++;
            if (pending_mappings.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want_map = pending_mappings.pop_front();
                if (m_prg_bank !== want_map.prg_bank)
                    report_mismatch($sformatf("prg_bank got %0h expected %0h",
                                              m_prg_bank, want_map.prg_bank));
                if (m_chr_bank !== want_map.chr_bank)
                    report_mismatch($sformatf("chr_bank got %0h expected %0h",
                                              m_chr_bank, want_map.chr_bank));
                if (m_screen_select !== want_map.screen_select)
                    report_mismatch($sformatf("screen_select got %0h expected %0h",
                                              m_screen_select, want_map.screen_select));
                if (m_prg_source !== want_map.prg_source)
                    report_mismatch($sformatf("prg_source got %0h expected %0h",
                                              m_prg_source, want_map.prg_source));
                if (m_flash_action !== want_map.flash_action)
                    report_mismatch($sformatf("flash_action got %0h expected %0h",
                                              m_flash_action, want_map.flash_action));
                if (m_flash_address !== want_map.flash_address)
                    report_mismatch($sformatf("flash_address got %0h expected %0h",
                                              m_flash_address, want_map.flash_address));
                if (m_program_data !== want_map.program_data)
                    report_mismatch($sformatf("program_data got %0h expected %0h",
                                              m_program_data, want_map.program_data));
            end
            stall_left = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
            m_ready <= (stall_left == 0);
        end else if (stall_left != 0) begin
            stall_left--;
            m_ready <= (stall_left == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // returns at the edge where the request was taken, valid still high
    task automatic send_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data,
                              input logic [DATA_W-1:0] cur);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_write_address <= addr;
        s_write_data    <= data;
        s_current_byte  <= cur;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pending_mappings.push_back(decode_cpu_write(addr, data, cur));
        items_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_mappings.size() != 0);
    endtask

    task automatic set_register(input logic idx, input logic value);
        drain_results();
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_FLASH_EN) begin
            flash_on = value;
        end else begin
            conflict_on = value;
        end
    endtask

    // load the latch through the $c000-$ffff half with a chosen bit 0
    task automatic latch_write(input logic bit0);
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] cur;
        val    = 8'($urandom);
        val[0] = bit0;
        cur    = 8'($urandom);
        cur[0] = 1'b1;
        send_write(ADDR_W'($urandom_range(LATCH_LOW, (1 << ADDR_W) - 1)), val, cur);
    endtask

    // 5555 needs latch bit 0 set, 2aaa needs it clear
    task automatic unlock_write(input logic hi, input logic [DATA_W-1:0] val,
                                input logic wrong_bank);
        logic want_bit;
        want_bit = hi ^ wrong_bank;
        if (bank_latch_q[0] != want_bit || $urandom_range(0, 3) == 0) begin
            latch_write(want_bit);
        end
        send_write(hi ? HI_WIN : LO_WIN, val, 8'($urandom));
    endtask

    task automatic flash_sequence(input flash_seq_t kind, input logic broken,
                                  input logic [DATA_W-1:0] final_cur);
        cmd_step_t         steps [$];
        int unsigned       k;
        seq_fault_t        fault;
        logic [DATA_W-1:0] val;
        logic              off_bank;
        steps.push_back(cmd_step_t'{1'b1, CMD_UNLOCK1});
        steps.push_back(cmd_step_t'{1'b0, CMD_UNLOCK2});
        case (kind)
            SEQ_ID: begin
                steps.push_back(cmd_step_t'{1'b1, CMD_ID_ENTRY});
            end
            SEQ_PROGRAM: begin
                steps.push_back(cmd_step_t'{1'b1, CMD_PROGRAM});
            end
            default: begin
                steps.push_back(cmd_step_t'{1'b1, CMD_ERASE});
                steps.push_back(cmd_step_t'{1'b1, CMD_UNLOCK1});
                steps.push_back(cmd_step_t'{1'b0, CMD_UNLOCK2});
                if (kind == SEQ_CHIP) begin
                    steps.push_back(cmd_step_t'{1'b1, CMD_CHIP});
                end
            end
        endcase
        k     = $urandom_range(0, steps.size() - 1);
        fault = seq_fault_t'($urandom_range(0, 3));
        foreach (steps[i]) begin
            val      = steps[i].val;
            off_bank = 1'b0;
            if (broken && i == k) begin
                case (fault)
                    BREAK_DATA:  val = 8'($urandom);
                    BREAK_BANK:  off_bank = 1'b1;
                    BREAK_NOISE: send_write(ADDR_W'($urandom), 8'($urandom), 8'($urandom));
                    default:     val = CMD_RESET;
                endcase
            end
            unlock_write(steps[i].hi, val, off_bank);
        end
        if (kind == SEQ_PROGRAM || kind == SEQ_SECTOR) begin
            if ($urandom_range(0, 1)) begin
                latch_write(1'($urandom));
            end
            send_write(ADDR_W'($urandom_range(0, LATCH_LOW - 1)),
                       kind == SEQ_SECTOR ? CMD_SECTOR : 8'($urandom), final_cur);
        end
    endtask

    task automatic test_latch_only();
        send_write('0, 8'hFF, 8'hFF);
        send_write('1, 8'hFF, 8'h00);
        send_write(ADDR_W'(LATCH_LOW), 8'hA5, 8'h5A);
        set_register(CFG_BUS_CONFLICT, 1'b0);
        send_write(ADDR_W'(LATCH_LOW - 1), 8'h00, 8'hFF);
        send_write('1, 8'hFF, 8'h00);
        // with flash off a command address only loads the latch
        send_write(HI_WIN, CMD_UNLOCK1, 8'h00);
        set_register(CFG_FLASH_EN, 1'b1);
        set_register(CFG_BUS_CONFLICT, 1'b1);
    endtask

    task automatic test_id_mode();
        flash_sequence(SEQ_ID, 1'b0, 8'h00);
        latch_write(1'($urandom));
        send_write(LO_WIN, CMD_RESET, 8'($urandom));
    endtask

    task automatic test_program();
        flash_sequence(SEQ_PROGRAM, 1'b0, ERASED_BYTE);
        flash_sequence(SEQ_PROGRAM, 1'b0, 8'h00);
    endtask

    task automatic test_erase();
        flash_sequence(SEQ_SECTOR, 1'b0, 8'($urandom));
        flash_sequence(SEQ_CHIP, 1'b0, 8'($urandom));
    endtask

    task automatic test_full_buffer();
        // fill all six entries without a match, then overrun
        repeat (8) send_write(ADDR_W'(CMD_LOW_HI), CMD_UNLOCK1, 8'($urandom));
        send_write('0, 8'h00, 8'h00);
        flash_sequence(SEQ_PROGRAM, 1'b0, ERASED_BYTE);
    endtask

    task automatic test_frozen_recogniser();
        unlock_write(1'b1, CMD_UNLOCK1, 1'b0);
        unlock_write(1'b0, CMD_UNLOCK2, 1'b0);
        set_register(CFG_FLASH_EN, 1'b0);
        send_write(HI_WIN, 8'h3C, 8'hFF);
        set_register(CFG_FLASH_EN, 1'b1);
        unlock_write(1'b1, CMD_PROGRAM, 1'b0);
        send_write(ADDR_W'($urandom_range(0, LATCH_LOW - 1)), 8'($urandom), ERASED_BYTE);
    endtask

    task automatic test_random_traffic();
        int unsigned       sel;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 7) == 0) begin
                no_gaps = !no_gaps;
            end
            sel = $urandom_range(0, 99);
            if (sel < 2) begin
                set_register(CFG_FLASH_EN, $urandom_range(0, 3) != 0);
                set_register(CFG_BUS_CONFLICT, 1'($urandom));
            end else if (sel < 60) begin
                flash_sequence(flash_seq_t'($urandom_range(0, 3)), 1'b0,
                               $urandom_range(0, 1) ? ERASED_BYTE : 8'($urandom));
            end else if (sel < 75) begin
                flash_sequence(flash_seq_t'($urandom_range(0, 3)), 1'b1,
                               $urandom_range(0, 1) ? ERASED_BYTE : 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    addr = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? HI_WIN : LO_WIN)
                                                : ADDR_W'($urandom);
                    data = $urandom_range(0, 2) == 0 ? ($urandom_range(0, 1) ? CMD_UNLOCK1
                                                                             : CMD_RESET)
                                                     : 8'($urandom);
                    send_write(addr, data, 8'($urandom));
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        flash_on     = 1'b0;
        conflict_on  = 1'b1;
        id_on        = 1'b0;
        bank_latch_q = '0;
        cmd_fill     = 0;
        foreach (cmd_addr_q[i]) begin
            cmd_addr_q[i] = '0;
            cmd_data_q[i] = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_latch_only();
        test_id_mode();
        test_program();
        test_erase();
        test_full_buffer();
        test_frozen_recogniser();
        test_random_traffic();
        drain_results();
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && pending_mappings.size() == 0) begin
            $display("cartridge_bank_latch_flash_commands: match");
        end else begin
            $display("cartridge_bank_latch_flash_commands: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/cblfc_pkg.sv
rtl/cartridge_bank_latch_flash_commands.sv
rtl/cblfc_checker.sv
tb/sv/tb_top.sv
